### rtl/positional_list_engine_unit_assert.svh
// Assertion macros used by the checker module of the list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

### rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
package ple_pkg;

	localparam int Capacity = 32;
	localparam int NodeW    = $clog2(Capacity);
	localparam int CountW   = $clog2(Capacity + 1);
	localparam int ModeW    = 2;
	localparam int PosW     = 6;
	localparam int ValueW   = 32;
	localparam int StatusW  = 2;

	typedef enum logic [ModeW-1:0] {
		MODE_INSERT = 2'd0,
		MODE_GET    = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [StatusW-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_GET_A,
		S_INS_A,
		S_INS_B,
		S_INS_C,
		S_DEL_A,
		S_DEL_B,
		S_DEL_C,
		S_TAKE,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DECODE,
		OP_CLEAR,
		OP_WALK,
		OP_ELEM_RD_CUR,
		OP_TAKE_RD,
		OP_INS_A,
		OP_INS_B_HEAD,
		OP_INS_B_MID,
		OP_INS_C,
		OP_DEL_A_HEAD,
		OP_DEL_A_MID,
		OP_DEL_B,
		OP_DEL_C
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		op_t op;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		mode_t mode;
		logic  bad_pos;
		logic  full;
		logic  pos_one;
		logic  walk_zero;
	} dp_status_t;

endpackage

### rtl/ple_ctrl.sv
// Controller state machine of the positional list engine.
module ple_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ple_pkg::dp_status_t st,
	output ple_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);

	ple_pkg::state_t state_q;
	ple_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (start) state_next = ple_pkg::S_DECODE;
			end
			ple_pkg::S_DECODE: begin
				if (st.mode == ple_pkg::MODE_CLEAR) state_next = ple_pkg::S_DONE;
				else if (st.bad_pos) state_next = ple_pkg::S_DONE;
				else if (st.mode == ple_pkg::MODE_INSERT && st.full) state_next = ple_pkg::S_DONE;
				else state_next = ple_pkg::S_WALK;
			end
			ple_pkg::S_WALK: begin
				if (st.walk_zero) begin
					unique case (st.mode)
						ple_pkg::MODE_GET:    state_next = ple_pkg::S_GET_A;
						ple_pkg::MODE_INSERT: state_next = ple_pkg::S_INS_A;
						default:              state_next = ple_pkg::S_DEL_A;
					endcase
				end
			end
			ple_pkg::S_GET_A: state_next = ple_pkg::S_TAKE;
			ple_pkg::S_INS_A: state_next = ple_pkg::S_INS_B;
			ple_pkg::S_INS_B: state_next = st.pos_one ? ple_pkg::S_DONE : ple_pkg::S_INS_C;
			ple_pkg::S_INS_C: state_next = ple_pkg::S_DONE;
			ple_pkg::S_DEL_A: state_next = st.pos_one ? ple_pkg::S_DEL_C : ple_pkg::S_DEL_B;
			ple_pkg::S_DEL_B: state_next = ple_pkg::S_DEL_C;
			ple_pkg::S_DEL_C: state_next = ple_pkg::S_TAKE;
			ple_pkg::S_TAKE:  state_next = ple_pkg::S_DONE;
			ple_pkg::S_DONE:  state_next = ple_pkg::S_IDLE;
			default:          state_next = ple_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = ple_pkg::OP_NONE;
		busy   = 1'b1;
		done   = 1'b0;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) cmd.op = ple_pkg::OP_LOAD;
			end
			ple_pkg::S_DECODE: begin
				cmd.op = (st.mode == ple_pkg::MODE_CLEAR) ? ple_pkg::OP_CLEAR
				                                          : ple_pkg::OP_DECODE;
			end
			ple_pkg::S_WALK: begin
				if (!st.walk_zero) cmd.op = ple_pkg::OP_WALK;
			end
			ple_pkg::S_GET_A: cmd.op = ple_pkg::OP_ELEM_RD_CUR;
			ple_pkg::S_INS_A: cmd.op = ple_pkg::OP_INS_A;
			ple_pkg::S_INS_B: begin
				cmd.op = st.pos_one ? ple_pkg::OP_INS_B_HEAD : ple_pkg::OP_INS_B_MID;
			end
			ple_pkg::S_INS_C: cmd.op = ple_pkg::OP_INS_C;
			ple_pkg::S_DEL_A: begin
				cmd.op = st.pos_one ? ple_pkg::OP_DEL_A_HEAD : ple_pkg::OP_DEL_A_MID;
			end
			ple_pkg::S_DEL_B: cmd.op = ple_pkg::OP_DEL_B;
			ple_pkg::S_DEL_C: cmd.op = ple_pkg::OP_DEL_C;
			ple_pkg::S_TAKE:  cmd.op = ple_pkg::OP_TAKE_RD;
			ple_pkg::S_DONE:  done = 1'b1;
			default:          cmd.op = ple_pkg::OP_NONE;
		endcase
	end

endmodule

### rtl/ple_dpath.sv
// Datapath of the positional list engine: node pool, links, walk pointer, result.
module ple_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ple_pkg::cmd_t                         cmd,
	input  logic [ple_pkg::ModeW-1:0]             mode,
	input  logic [ple_pkg::PosW-1:0]              position,
	input  logic signed [ple_pkg::ValueW-1:0]     value,
	output ple_pkg::dp_status_t                   st,
	output logic [ple_pkg::StatusW-1:0]           status,
	output logic signed [ple_pkg::ValueW-1:0]     read_value,
	output logic [ple_pkg::CountW-1:0]            length
);

	localparam int NW = ple_pkg::NodeW;
	localparam int CW = ple_pkg::CountW;
	localparam int PW = ple_pkg::PosW;
	localparam int VW = ple_pkg::ValueW;
	localparam int CmpW = (PW > CW ? PW : CW) + 1;

	// Request registers.
	ple_pkg::mode_t       mode_q;
	logic [PW-1:0]        pos_q;
	logic signed [VW-1:0] val_q;

	// List bookkeeping.
	logic [NW-1:0] first_q;
	logic [NW-1:0] free_q;
	logic [CW-1:0] count_q;
	logic [NW-1:0] cur_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] tmp_q;
	logic [PW-1:0] cnt_q;

	// Result registers.
	ple_pkg::status_t     status_q;
	logic signed [VW-1:0] rd_q;

	// Link store: entries plus valid bits; an invalid entry reads its reset successor.
	logic [NW-1:0]             link_q [ple_pkg::Capacity];
	logic [ple_pkg::Capacity-1:0] link_valid_q;
	logic [NW-1:0]             link_rd_addr;
	logic [NW-1:0]             link_rd;
	logic                      link_we;
	logic [NW-1:0]             link_wr_addr;
	logic [NW-1:0]             link_wr_data;

	// Element store.
	logic signed [VW-1:0] elem_mem [ple_pkg::Capacity];
	logic signed [VW-1:0] elem_rd_q;
	logic [NW-1:0]        elem_rd_addr;

	logic                 bad_pos;
	logic                 full;
	logic                 pos_one;
	logic [CmpW-1:0]      limit;
	logic [PW-1:0]        walk_init;
	ple_pkg::status_t     status_code;

	always_comb begin
		unique case (cmd.op)
			ple_pkg::OP_INS_A:      link_rd_addr = free_q;
			ple_pkg::OP_DEL_A_HEAD: link_rd_addr = first_q;
			ple_pkg::OP_DEL_B:      link_rd_addr = node_q;
			default:                link_rd_addr = cur_q;
		endcase
		link_rd = link_valid_q[link_rd_addr] ? link_q[link_rd_addr]
		                                     : NW'((32'(link_rd_addr) + 32'd1) % ple_pkg::Capacity);
	end

	always_comb begin
		link_we      = 1'b0;
		link_wr_addr = node_q;
		link_wr_data = first_q;
		unique case (cmd.op)
			ple_pkg::OP_INS_B_HEAD: begin
				link_we      = 1'b1;
				link_wr_addr = node_q;
				link_wr_data = first_q;
			end
			ple_pkg::OP_INS_B_MID: begin
				link_we      = 1'b1;
				link_wr_addr = cur_q;
				link_wr_data = node_q;
			end
			ple_pkg::OP_INS_C: begin
				link_we      = 1'b1;
				link_wr_addr = node_q;
				link_wr_data = tmp_q;
			end
			ple_pkg::OP_DEL_B: begin
				link_we      = 1'b1;
				link_wr_addr = cur_q;
				link_wr_data = link_rd;
			end
			ple_pkg::OP_DEL_C: begin
				link_we      = 1'b1;
				link_wr_addr = node_q;
				link_wr_data = free_q;
			end
			default: link_we = 1'b0;
		endcase
	end

	assign elem_rd_addr = (cmd.op == ple_pkg::OP_DEL_C) ? node_q : cur_q;

	// Range and capacity checks on the latched request.
	assign pos_one = (pos_q == PW'(1));
	assign full    = (count_q == CW'(ple_pkg::Capacity));
	assign limit   = CmpW'(count_q) + ((mode_q == ple_pkg::MODE_INSERT) ? CmpW'(1) : CmpW'(0));
	assign bad_pos = (pos_q == '0) || (CmpW'(pos_q) > limit);

	always_comb begin
		if (bad_pos) status_code = ple_pkg::STATUS_RANGE;
		else if (mode_q == ple_pkg::MODE_INSERT && full) status_code = ple_pkg::STATUS_FULL;
		else status_code = ple_pkg::STATUS_OK;
	end

	// Get walks to the element itself, insert and delete to its predecessor.
	always_comb begin
		if (mode_q == ple_pkg::MODE_GET) walk_init = pos_q - PW'(1);
		else if (pos_one) walk_init = '0;
		else walk_init = pos_q - PW'(2);
	end

	assign st.mode      = mode_q;
	assign st.bad_pos   = bad_pos;
	assign st.full      = full;
	assign st.pos_one   = pos_one;
	assign st.walk_zero = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= '0;
			free_q       <= '0;
			count_q      <= '0;
			link_valid_q <= '0;
		end else begin
			unique case (cmd.op)
				ple_pkg::OP_CLEAR: begin
					first_q      <= '0;
					free_q       <= '0;
					count_q      <= '0;
					link_valid_q <= '0;
				end
				ple_pkg::OP_INS_A: begin
					free_q  <= link_rd;
					count_q <= count_q + CW'(1);
				end
				ple_pkg::OP_INS_B_HEAD: first_q <= node_q;
				ple_pkg::OP_DEL_A_HEAD: first_q <= link_rd;
				ple_pkg::OP_DEL_C: begin
					free_q  <= node_q;
					count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
			if (link_we) link_valid_q[link_wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) link_q[link_wr_addr] <= link_wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ple_pkg::OP_INS_A) elem_mem[free_q] <= val_q;
		elem_rd_q <= elem_mem[elem_rd_addr];
	end

	// Request, walk and result registers carry no reset.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ple_pkg::OP_LOAD: begin
				mode_q <= ple_pkg::mode_t'(mode);
				pos_q  <= position;
				val_q  <= value;
			end
			ple_pkg::OP_CLEAR: begin
				status_q <= ple_pkg::STATUS_OK;
				rd_q     <= '0;
			end
			ple_pkg::OP_DECODE: begin
				status_q <= status_code;
				rd_q     <= '0;
				cur_q    <= first_q;
				cnt_q    <= walk_init;
			end
			ple_pkg::OP_WALK: begin
				cur_q <= link_rd;
				cnt_q <= cnt_q - PW'(1);
			end
			ple_pkg::OP_TAKE_RD:   rd_q   <= elem_rd_q;
			ple_pkg::OP_INS_A:     node_q <= free_q;
			ple_pkg::OP_INS_B_MID: tmp_q  <= link_rd;
			ple_pkg::OP_DEL_A_HEAD: node_q <= first_q;
			ple_pkg::OP_DEL_A_MID:  node_q <= link_rd;
			default: begin
			end
		endcase
	end

	assign status     = status_q;
	assign read_value = rd_q;
	assign length     = count_q;

endmodule

### rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: controller plus datapath.
//
// Bounded singly linked list of up to 32 signed 32-bit elements in a node pool with a
// free chain. Raise start with mode, position and value; the transaction is taken on
// a rising edge where start is high and busy is low, and busy stays high until the
// result is delivered. One request is in flight at a time. The result (status,
// read_value, length) is shown for exactly one cycle while done is high; the receiver
// cannot stall it, so it must capture it in that cycle. Errors and clear go straight from
// the check to done; get, insert and delete first walk the pointer, so they take longer the
// larger the position. The pointer walk follows one link of the single-ported link store
// per cycle from the first element toward the target.
// After reset the pool is ready at once; clear restores the free chain by resetting the
// link valid bits.
module positional_list_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [ple_pkg::ModeW-1:0]            mode,
	input  logic [ple_pkg::PosW-1:0]             position,
	input  logic signed [ple_pkg::ValueW-1:0]    value,
	output logic                                 done,
	output logic [ple_pkg::StatusW-1:0]          status,
	output logic signed [ple_pkg::ValueW-1:0]    read_value,
	output logic [ple_pkg::CountW-1:0]           length
);

	ple_pkg::cmd_t       cmd;
	ple_pkg::dp_status_t st;

	// Sequence each transaction: latch, check, walk, update links, report.
	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold the node pool, free chain and result registers.
	ple_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.position   (position),
		.value      (value),
		.st         (st),
		.status     (status),
		.read_value (read_value),
		.length     (length)
	);

endmodule

### rtl/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
`include "positional_list_engine_unit_assert.svh"

module ple_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [ple_pkg::StatusW-1:0]          status,
	input logic signed [ple_pkg::ValueW-1:0]    read_value,
	input logic [ple_pkg::CountW-1:0]           length
);

	// An accepted transaction keeps the engine busy in the next cycle.
	`PLE_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// A result lasts one cycle only.
	`PLE_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// A result is only reported while a transaction is in flight.
	`PLE_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)
	// A failed request returns no data.
	`PLE_ASSERT_NOW(a_err_zero, clk, arst_n, done && status != ple_pkg::STATUS_OK, read_value == '0)
	// The list never holds more than the pool.
	`PLE_ASSERT_NOW(a_len_cap, clk, arst_n, done, length <= ple_pkg::CountW'(ple_pkg::Capacity))

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.read_value (read_value),
	.length     (length)
);
